// ===== rtl/core/ddcm_pkg.sv =====
// shared constants and codes for the dual deque card mover
package ddcm_pkg;

  localparam int unsigned DEPTH_DEF       = 1024;
  localparam int unsigned VALUE_WIDTH_DEF = 16;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_MOVE = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  localparam int unsigned CODE_SRC      = 3;
  localparam int unsigned CODE_SRC_BACK = 2;
  localparam int unsigned CODE_DST      = 1;
  localparam int unsigned CODE_DST_BACK = 0;

endpackage

// ===== rtl/core/ddcm_ram.sv =====
// single write port, single registered read port card store
module ddcm_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/dual_deque_card_mover_core.sv =====
// top level of the dual deque card mover
// Two double-ended queues of cards, A and B, each held in its own store.
// The input channel (in_valid, in_stall) carries one command per transfer:
// mode 0 pushes value onto the back of deque deque_sel, mode 1 moves a card
// as op_code directs (source, source end, destination, destination end),
// mode 2 pops the front of deque deque_sel, mode 3 only reports the fill.
// The output channel (out_valid, out_stall) returns exactly one result per
// command: card, count in the addressed or destination deque, and status
// (done, source empty, destination full with the card dropped).
// Loads, commands on an empty source and mode 3 have their result
// registered at the accepting edge. Moves and pops pass through S_READ,
// since the store read is registered; the result and the write of a move
// are made in S_READ. One command is in work at a time.
// A finished result waits in the output register while the next command is
// accepted; if that one finishes while the receiver still stalls, it waits
// in a holding register and in_stall stays high until the output drains.
// Reset empties both deques and the output and holds in_stall high; store
// contents are not cleared.
module dual_deque_card_mover_core
  import ddcm_pkg::*;
#(
  parameter int unsigned DEPTH       = DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       mode,
  input  logic                             deque_sel,
  input  logic [3:0]                       op_code,
  input  logic signed [VALUE_WIDTH-1:0]    value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [VALUE_WIDTH-1:0]    card,
  output logic [$clog2(DEPTH+1)-1:0]       count,
  output logic [1:0]                       status
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_HOLD
  } state_t;

  state_t state;

  logic [AW-1:0] head_a, tail_a, head_b, tail_b;
  logic [CW-1:0] fill_a, fill_b;
  logic [AW-1:0] head_a_next, tail_a_next, head_b_next, tail_b_next;
  logic [CW-1:0] fill_a_next, fill_b_next;

  logic rd_src, mv_dst, mv_dst_back, mv_is_move;

  logic signed [VALUE_WIDTH-1:0] pend_card;
  logic [CW-1:0]                 pend_count;
  logic [1:0]                    pend_status;

  logic signed [VALUE_WIDTH-1:0] res_card;
  logic [CW-1:0]                 res_count;
  logic [1:0]                    res_status;
  logic                          res_en;

  logic acc, out_free;
  logic take_pend, take_res;
  logic src, src_back;
  logic [AW-1:0] src_head, src_tail;
  logic [CW-1:0] src_fill, sel_fill;
  logic pop_en;
  logic [AW-1:0] pop_idx;

  logic push_en, push_q, push_back;
  logic [AW-1:0] push_head, push_tail, push_idx;
  logic [CW-1:0] push_fill;
  logic [VALUE_WIDTH-1:0] push_data;
  logic push_try;

  logic [VALUE_WIDTH-1:0] rd_data_a, rd_data_b, rd_card;
  logic cnt_q;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] i);
    return (i == LAST) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] i);
    return (i == '0) ? LAST : i - 1'b1;
  endfunction

  assign in_stall = rst || (state != S_IDLE);
  assign acc      = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // pop side, decided at the accepting edge
  assign src      = (mode == MODE_MOVE) ? op_code[CODE_SRC] : deque_sel;
  assign src_back = (mode == MODE_MOVE) && op_code[CODE_SRC_BACK];
  assign src_head = src ? head_b : head_a;
  assign src_tail = src ? tail_b : tail_a;
  assign src_fill = src ? fill_b : fill_a;
  assign sel_fill = deque_sel ? fill_b : fill_a;
  assign pop_en   = acc && ((mode == MODE_MOVE) || (mode == MODE_READ)) && (src_fill != '0);
  assign pop_idx  = src_back ? wrap_dec(src_tail) : src_head;

  // push side: load at the accepting edge, move destination in the read cycle
  always_comb begin
    if (state == S_READ) begin
      push_q    = mv_dst;
      push_back = mv_dst_back;
      push_try  = mv_is_move;
      push_data = rd_card;
    end else begin
      push_q    = deque_sel;
      push_back = 1'b1;
      push_try  = acc && (mode == MODE_LOAD);
      push_data = value;
    end
  end

  assign push_head = push_q ? head_b : head_a;
  assign push_tail = push_q ? tail_b : tail_a;
  assign push_fill = push_q ? fill_b : fill_a;
  assign push_en   = push_try && (push_fill != FULL);
  assign push_idx  = push_back ? push_tail : wrap_dec(push_head);

  assign rd_card = rd_src ? rd_data_b : rd_data_a;

  ddcm_ram #(
    .DEPTH (DEPTH),
    .WIDTH (VALUE_WIDTH)
  ) u_store_a (
    .clk     (clk),
    .wr_en   (push_en && !push_q),
    .wr_addr (push_idx),
    .wr_data (push_data),
    .rd_addr (pop_idx),
    .rd_data (rd_data_a)
  );

  ddcm_ram #(
    .DEPTH (DEPTH),
    .WIDTH (VALUE_WIDTH)
  ) u_store_b (
    .clk     (clk),
    .wr_en   (push_en && push_q),
    .wr_addr (push_idx),
    .wr_data (push_data),
    .rd_addr (pop_idx),
    .rd_data (rd_data_b)
  );

  // pointer updates
  always_comb begin
    head_a_next = head_a;
    tail_a_next = tail_a;
    fill_a_next = fill_a;
    head_b_next = head_b;
    tail_b_next = tail_b;
    fill_b_next = fill_b;
    if (pop_en) begin
      if (!src) begin
        if (src_back) begin
          tail_a_next = wrap_dec(tail_a);
        end else begin
          head_a_next = wrap_inc(head_a);
        end
        fill_a_next = fill_a - 1'b1;
      end else begin
        if (src_back) begin
          tail_b_next = wrap_dec(tail_b);
        end else begin
          head_b_next = wrap_inc(head_b);
        end
        fill_b_next = fill_b - 1'b1;
      end
    end
    if (push_en) begin
      if (!push_q) begin
        if (push_back) begin
          tail_a_next = wrap_inc(tail_a);
        end else begin
          head_a_next = wrap_dec(head_a);
        end
        fill_a_next = fill_a + 1'b1;
      end else begin
        if (push_back) begin
          tail_b_next = wrap_inc(tail_b);
        end else begin
          head_b_next = wrap_dec(head_b);
        end
        fill_b_next = fill_b + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_a <= '0;
      tail_a <= '0;
      fill_a <= '0;
      head_b <= '0;
      tail_b <= '0;
      fill_b <= '0;
    end else begin
      head_a <= head_a_next;
      tail_a <= tail_a_next;
      fill_a <= fill_a_next;
      head_b <= head_b_next;
      tail_b <= tail_b_next;
      fill_b <= fill_b_next;
    end
  end

  // result of the current step
  always_comb begin
    if (state == S_READ) begin
      cnt_q      = mv_dst;
      res_en     = 1'b1;
      res_card   = $signed(rd_card);
      res_status = (mv_is_move && !push_en) ? STAT_FULL : STAT_DONE;
    end else begin
      cnt_q      = (mode == MODE_MOVE) ? op_code[CODE_DST] : deque_sel;
      res_en     = acc && !pop_en;
      res_card   = '0;
      res_status = STAT_DONE;
      if ((mode == MODE_LOAD) && !push_en) begin
        res_status = STAT_FULL;
      end else if (((mode == MODE_MOVE) && (src_fill == '0)) ||
                   ((mode == MODE_READ) && (sel_fill == '0))) begin
        res_status = STAT_EMPTY;
      end
    end
    res_count = cnt_q ? fill_b_next : fill_a_next;
  end

  assign take_pend = (state == S_HOLD) && out_free;
  assign take_res  = res_en && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (pop_en) begin
            state       <= S_READ;
            rd_src      <= src;
            mv_is_move  <= (mode == MODE_MOVE);
            mv_dst      <= (mode == MODE_MOVE) ? op_code[CODE_DST] : deque_sel;
            mv_dst_back <= op_code[CODE_DST_BACK];
          end else if (res_en && !out_free) begin
            state <= S_HOLD;
          end
        end
        S_READ: begin
          state <= out_free ? S_IDLE : S_HOLD;
        end
        S_HOLD: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (take_pend) begin
        out_valid <= 1'b1;
        card      <= pend_card;
        count     <= pend_count;
        status    <= pend_status;
      end else if (take_res) begin
        out_valid <= 1'b1;
        card      <= res_card;
        count     <= res_count;
        status    <= res_status;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (res_en && !out_free) begin
        pend_card   <= res_card;
        pend_count  <= res_count;
        pend_status <= res_status;
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (fill_a <= FULL) && (fill_b <= FULL))
    else $error("deque fill beyond depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    ((fill_a != '0) || (head_a == tail_a)) && ((fill_b != '0) || (head_b == tail_b)))
    else $error("empty deque with head and tail apart");

  a_pop_reads: assert property (@(posedge clk) disable iff (rst)
    pop_en |=> (state == S_READ))
    else $error("pop not followed by store read cycle");

  a_empty_card: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == STAT_EMPTY)) |-> (card == '0))
    else $error("empty source reported a card");

endmodule

// ===== verif/tb_dual_deque_card_mover_core.sv =====
// testbench for dual_deque_card_mover_core: predicted deque results checked per transfer
`timescale 1ns / 100ps

module tb_dual_deque_card_mover_core;
  import ddcm_pkg::*;

  localparam int unsigned DEPTH    = DEPTH_DEF;
  localparam int unsigned VW       = VALUE_WIDTH_DEF;
  localparam int unsigned AW       = $clog2(DEPTH);
  localparam int unsigned COUNT_W  = $clog2(DEPTH + 1);
  localparam logic [1:0]  MODE_RSVD = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned RANDOM_ITEMS = 400;

  typedef struct packed {
    logic [VW-1:0]      card;
    logic [COUNT_W-1:0] count;
    logic [1:0]         status;
  } card_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] mode = MODE_LOAD;
  logic deque_sel = 1'b0;
  logic [3:0] op_code = 4'd0;
  logic signed [VW-1:0] value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [VW-1:0] card;
  logic [COUNT_W-1:0] count;
  logic [1:0] status;

  logic [VW-1:0] card_store [2][DEPTH];
  logic [AW-1:0] front_idx [2];
  logic [AW-1:0] back_idx [2];
  int unsigned held [2];
  card_result_t expected_results [$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned checked_count = 0;
  int unsigned load_count = 0;
  int unsigned move_count = 0;
  int unsigned read_count = 0;
  int unsigned rsvd_count = 0;
  int unsigned full_count = 0;
  int unsigned empty_count = 0;
  int unsigned burst_left = 0;
  int unsigned hold_left = 0;
  int unsigned phase_left = 0;
  int unsigned stall_pct = 0;

  dual_deque_card_mover_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .deque_sel (deque_sel),
    .op_code   (op_code),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .card      (card),
    .count     (count),
    .status    (status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [3:0] make_code(input logic src, input logic src_back,
                                           input logic dst, input logic dst_back);
    logic [3:0] c;
    c = '0;
    c[CODE_SRC]      = src;
    c[CODE_SRC_BACK] = src_back;
    c[CODE_DST]      = dst;
    c[CODE_DST_BACK] = dst_back;
    return c;
  endfunction

  function automatic bit push_card(input logic s, input bit at_back, input logic [VW-1:0] v);
    if (held[s] >= DEPTH) return 1'b0;
    if (at_back) begin
      card_store[s][back_idx[s]] = v;
      back_idx[s] = AW'((back_idx[s] + 1) % DEPTH);
    end else begin
      front_idx[s] = AW'((front_idx[s] + DEPTH - 1) % DEPTH);
      card_store[s][front_idx[s]] = v;
    end
    held[s]++;
    return 1'b1;
  endfunction

  function automatic logic [VW-1:0] pop_card(input logic s, input bit at_back);
    logic [VW-1:0] v;
    if (at_back) begin
      back_idx[s] = AW'((back_idx[s] + DEPTH - 1) % DEPTH);
      v = card_store[s][back_idx[s]];
    end else begin
      v = card_store[s][front_idx[s]];
      front_idx[s] = AW'((front_idx[s] + 1) % DEPTH);
    end
    held[s]--;
    return v;
  endfunction

  function automatic card_result_t predict_command(input logic [1:0] m, input logic sel,
                                                   input logic [3:0] code,
                                                   input logic [VW-1:0] v);
    card_result_t r;
    logic src;
    logic dst;
    r = '0;
    src = code[CODE_SRC];
    dst = code[CODE_DST];
    case (m)
      MODE_LOAD: begin
        if (!push_card(sel, 1'b1, v)) r.status = STAT_FULL;
        r.count = COUNT_W'(held[sel]);
      end
      MODE_MOVE: begin
        if (held[src] == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.card = pop_card(src, code[CODE_SRC_BACK]);
          if (!push_card(dst, code[CODE_DST_BACK], r.card)) r.status = STAT_FULL;
        end
        r.count = COUNT_W'(held[dst]);
      end
      MODE_READ: begin
        if (held[sel] == 0) r.status = STAT_EMPTY;
        else r.card = pop_card(sel, 1'b0);
        r.count = COUNT_W'(held[sel]);
      end
      default: begin
        r.count = COUNT_W'(held[sel]);
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [VW-1:0] got,
                                 input logic [VW-1:0] want);
    $display("mismatch at cycle %0d, %s: got %0h want %0h", cycle_count, what, got, want);
    error_count++;
  endtask

  // one command, held until the block takes it
  task automatic send_command(input logic [1:0] cmd_mode, input logic cmd_sel,
                              input logic [3:0] cmd_code, input logic [VW-1:0] cmd_value);
    int unsigned gap;
    card_result_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    mode      <= cmd_mode;
    deque_sel <= cmd_sel;
    op_code   <= cmd_code;
    value     <= cmd_value;
    do @(posedge clk); while (!(in_valid && !in_stall));
    r = predict_command(cmd_mode, cmd_sel, cmd_code, cmd_value);
    expected_results.push_back(r);
    case (cmd_mode)
      MODE_LOAD: load_count++;
      MODE_MOVE: move_count++;
      MODE_READ: read_count++;
      default:   rsvd_count++;
    endcase
    if (r.status == STAT_FULL) full_count++;
    if (r.status == STAT_EMPTY) empty_count++;
  endtask

  task automatic send_random_command();
    int unsigned pick;
    logic [1:0] m;
    pick = $urandom_range(0, 99);
    if (pick < 38) m = MODE_LOAD;
    else if (pick < 72) m = MODE_MOVE;
    else if (pick < 96) m = MODE_READ;
    else m = MODE_RSVD;
    send_command(m, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), VW'($urandom));
  endtask

  // receiver stall pattern, with a long hold-off that the backpressure test sets
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (phase_left == 0) begin
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 25;
          default: stall_pct = 65;
        endcase
        phase_left = $urandom_range(8, 60);
      end
      phase_left--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    card_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing outstanding", card, '0);
      end else begin
        want = expected_results.pop_front();
        checked_count++;
        if (card !== want.card) report_mismatch("card", card, want.card);
        if (count !== want.count) report_mismatch("count", VW'(count), VW'(want.count));
        if (status !== want.status) report_mismatch("status", VW'(status), VW'(want.status));
      end
    end
  end

  task automatic test_directed();
    send_command(MODE_READ, 1'b0, 4'd0, '0);
    send_command(MODE_READ, 1'b1, 4'd0, '0);
    send_command(MODE_MOVE, 1'b0, make_code(1'b1, 1'b1, 1'b0, 1'b0), '0);
    send_command(MODE_RSVD, 1'b1, 4'd0, '0);
    send_command(MODE_LOAD, 1'b0, 4'd0, 16'h8000);
    send_command(MODE_LOAD, 1'b0, 4'd0, 16'h7FFF);
    send_command(MODE_LOAD, 1'b1, 4'd0, 16'hFFFF);
    send_command(MODE_LOAD, 1'b1, 4'd0, 16'h0000);
    for (int c = 0; c < 16; c++) begin
      send_command(MODE_MOVE, c[0], c[3:0], '0);
    end
  endtask

  // fill deque a past full, move into it from both deques, then pop a few
  task automatic test_full_deque();
    while (held[0] < DEPTH) begin
      send_command(MODE_LOAD, 1'b0, 4'($urandom_range(0, 15)), VW'($urandom));
    end
    send_command(MODE_LOAD, 1'b0, 4'($urandom_range(0, 15)), VW'($urandom));
    if (held[1] == 0) send_command(MODE_LOAD, 1'b1, 4'd0, VW'($urandom));
    send_command(MODE_MOVE, 1'b0, make_code(1'b1, 1'b1, 1'b0, 1'b0), '0);
    send_command(MODE_MOVE, 1'b0, make_code(1'b0, 1'b1, 1'b0, 1'b0), '0);
    send_command(MODE_MOVE, 1'b0, make_code(1'b0, 1'b0, 1'b0, 1'b1), '0);
    send_command(MODE_RSVD, 1'b0, 4'd0, '0);
    repeat (8) send_command(MODE_READ, 1'b0, 4'd0, '0);
  endtask

  task automatic test_backpressure();
    hold_left = 300;
    repeat (30) send_random_command();
  endtask

  task automatic test_random();
    repeat (RANDOM_ITEMS) send_random_command();
  endtask

  task automatic wait_for_results();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    front_idx = '{default: '0};
    back_idx  = '{default: '0};
    held      = '{default: 0};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_full_deque();
    test_backpressure();
    test_random();
    in_valid <= 1'b0;
    wait_for_results();
    repeat (20) @(posedge clk);
    if (expected_results.size() != 0) begin
      report_mismatch("results never returned", VW'(expected_results.size()), '0);
    end
    $display("covered %0d loads, %0d moves, %0d readouts, %0d reserved-mode commands",
             load_count, move_count, read_count, rsvd_count);
    $display("full drops %0d, empty sources %0d, results checked %0d, mismatches %0d",
             full_count, empty_count, checked_count, error_count);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
